### hw/rtl/tkpwq_pkg.sv
// Package for the two-key priority wait queue: entry type, operation and
// status codes, controller states, reset constants and the tie-break LFSR step.
// No dependencies.
package tkpwq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;
  localparam logic [15:0] TIE_SEED_RESET      = 16'd44257;
  localparam logic [15:0] LFSR_TAPS           = 16'hB400;

  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_BOARD = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_POP,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] fare;
    logic [2:0]  cls;
  } entry_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] cur);
    logic [15:0] nxt;
    nxt = {1'b0, cur[15:1]};
    if (cur[0]) begin
      nxt = nxt ^ LFSR_TAPS;
    end
    return nxt;
  endfunction

endpackage

### hw/rtl/two_key_priority_wait_queue.sv
// Top level of the two-key priority wait queue.
// Depends on tkpwq_pkg for the entry type, codes, states and the LFSR step.
//
// Usage: an input beat (func_i, customer_id_i, fare_i, flight_class_i) is
// taken when in_valid_i is high and in_stall_o is low. An add inserts the
// entry in order of class (low first) and then fare (high first); equal keys
// are ordered by one bit of a 16-bit LFSR. A board removes the head entry.
// Every input beat gives exactly one output beat with status, the boarded
// entry (zero otherwise) and the count after the operation.
// The queue lies in one synchronous memory used as a ring with a head pointer.
// A board reads the head entry on accept, then passes ST_POP and ST_RESP to
// the output register; a refused item or an add to an empty queue goes straight
// to ST_RESP. An add scans from the tail toward the head, reading one entry and
// moving it back one slot per cycle, and writes the new entry behind the first
// one that stays ahead of it, or at the head in ST_PLACE. One item is in work at
// a time; the next one is taken once the result sits in the output register.
// When the receiver stalls, the output beat holds and the block finishes at
// most one further item before it waits. Reset empties the queue and loads
// the seed register (reset value 44257) into the LFSR; writing the seed
// register also reloads the LFSR.
module two_key_priority_wait_queue
  import tkpwq_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [15:0] customer_id_i,
  input  logic [15:0] fare_i,
  input  logic [2:0]  flight_class_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_id_o,
  output logic [15:0] out_fare_o,
  output logic [2:0]  out_class_o,
  output logic [4:0]  waiting_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            tie_q, tie_d;
  logic [15:0]     seed_q, seed_d;
  logic [15:0]     lfsr_q, lfsr_d;
  entry_t          item_q, item_d;
  status_e         res_status_q, res_status_d;
  entry_t          res_entry_q, res_entry_d;
  logic            out_valid_q, out_valid_d;
  status_e         out_status_q, out_status_d;
  entry_t          out_entry_q, out_entry_d;
  logic [4:0]      out_count_q, out_count_d;

  entry_t          mem_q [QueueDepth];
  entry_t          rd_data_q;
  logic            rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;
  entry_t          wr_data;

  logic            accept, cfg_wr, out_free, ahead, full, empty;
  logic [IdxW-1:0] idx_next, idx_prev, tail_idx;

  function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] head,
                                           input logic [IdxW-1:0] off);
    logic [IdxW:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= (IdxW+1)'(QueueDepth)) begin
      s = s - (IdxW+1)'(QueueDepth);
    end
    return s[IdxW-1:0];
  endfunction

  assign accept   = in_valid_i && !in_stall_o;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (count_q == CntW'(QueueDepth));
  assign empty    = (count_q == '0);
  assign idx_next = idx_q + IdxW'(1);
  assign idx_prev = idx_q - IdxW'(1);
  assign tail_idx = IdxW'(count_q - CntW'(1));

  always_comb begin
    if (rd_data_q.cls != item_q.cls) begin
      ahead = rd_data_q.cls < item_q.cls;
    end else if (rd_data_q.fare != item_q.fare) begin
      ahead = rd_data_q.fare > item_q.fare;
    end else begin
      ahead = !tie_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_ADD) begin
            state_d = (full || empty) ? ST_RESP : ST_SCAN;
          end else begin
            state_d = empty ? ST_RESP : ST_POP;
          end
        end
      end
      ST_SCAN: begin
        if (ahead) begin
          state_d = ST_RESP;
        end else if (idx_q == '0) begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: state_d = ST_RESP;
      ST_POP:   state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    tie_d        = tie_q;
    seed_d       = seed_q;
    lfsr_d       = lfsr_q;
    item_d       = item_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_count_d  = out_count_q;
    rd_en        = 1'b0;
    rd_addr      = head_q;
    wr_en        = 1'b0;
    wr_addr      = head_q;
    wr_data      = item_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d       = '{id: customer_id_i, fare: fare_i, cls: flight_class_i};
          res_status_d = STAT_DONE;
          res_entry_d  = '0;
          if (func_i == FUNC_ADD) begin
            if (full) begin
              res_status_d = STAT_FULL;
            end else begin
              tie_d  = lfsr_q[0];
              lfsr_d = lfsr_step(lfsr_q);
              if (empty) begin
                wr_en   = 1'b1;
                wr_addr = head_q;
                wr_data = item_d;
                count_d = CntW'(1);
              end else begin
                rd_en   = 1'b1;
                rd_addr = phys(head_q, tail_idx);
                idx_d   = tail_idx;
              end
            end
          end else begin
            if (empty) begin
              res_status_d = STAT_EMPTY;
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_q;
            end
          end
        end
      end
      ST_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_q, idx_next);
        if (ahead) begin
          wr_data = item_q;
          count_d = count_q + CntW'(1);
        end else begin
          wr_data = rd_data_q;
          if (idx_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = phys(head_q, idx_prev);
            idx_d   = idx_prev;
          end
        end
      end
      ST_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = head_q;
        wr_data = item_q;
        count_d = count_q + CntW'(1);
      end
      ST_POP: begin
        res_entry_d = rd_data_q;
        head_d      = (head_q == IdxW'(QueueDepth - 1)) ? '0 : head_q + IdxW'(1);
        count_d     = count_q - CntW'(1);
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_entry_d  = res_entry_q;
          out_count_d  = 5'(count_q);
        end
      end
      default: ;
    endcase
    if (cfg_wr) begin
      seed_d = pwdata[15:0];
      lfsr_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      tie_q       <= 1'b0;
      seed_q      <= TIE_SEED_RESET;
      lfsr_q      <= TIE_SEED_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      tie_q       <= tie_d;
      seed_q      <= seed_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_count_q  <= out_count_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign out_id_o        = out_entry_q.id;
  assign out_fare_o      = out_entry_q.fare;
  assign out_class_o     = out_entry_q.cls;
  assign waiting_count_o = out_count_q;
  assign prdata          = (paddr[2] == 1'b0) ? {16'd0, seed_q} : 32'd0;
  assign pready          = 1'b1;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("Entry count exceeds the queue depth.");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("An accepted beat did not start an operation.");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> (CntW'(idx_q) < count_q) && !full)
    else $error("Scan index lies outside the occupied entries.");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_EMPTY |-> waiting_count_o == 5'd0 && out_id_o == 16'd0)
    else $error("A refused board reports a nonempty queue or an entry.");

endmodule
